[hdl/mspw_pkg.sv]
// shared types and constants for the multi-sensor pulse width window unit
// no dependencies
package mspw_pkg;

  localparam int unsigned LEVEL_W     = 12;
  localparam int unsigned WINDOW_W    = 16;
  localparam int unsigned INC_W       = 8;
  localparam int unsigned OUT_IDX_W   = 4;
  localparam int unsigned OUT_WIDTH_W = 24;
  localparam int unsigned OUT_CNT_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_INCREMENT = 1'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [INC_W-1:0]    INC_RESET    = 8'd1;

  typedef struct packed {
    logic accum;
    logic scan_step;
    logic out_step;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic ptr_last;
  } status_t;

endpackage

[hdl/mspw_ctrl.sv]
// control state machine: sampling, strongest-sensor scan, result readout
// depends on mspw_pkg
module mspw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mspw_pkg::status_t status_i,
  output mspw_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_ACCUM = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o  = 1'b1;
        cmd_o.accum = in_valid_i;
        if (in_valid_i && status_i.close) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.ptr_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_o    = 1'b1;
        cmd_o.out_step = out_ready_i;
        if (out_ready_i && status_i.ptr_last) begin
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

endmodule

[hdl/mspw_datapath.sv]
// datapath: config registers, saturating width accumulators, sample counter,
// sequential active/strongest scan and readout pointer; depends on mspw_pkg
module mspw_datapath #(
  parameter int unsigned SENSOR_COUNT = 12,
  parameter int unsigned WIDTH_BITS   = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mspw_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mspw_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [mspw_pkg::LEVEL_W-1:0]           sensor_levels_i,
  input  mspw_pkg::cmd_t                         cmd_i,
  output mspw_pkg::status_t                      status_o,
  output logic [mspw_pkg::OUT_IDX_W-1:0]         sensor_index_o,
  output logic [mspw_pkg::OUT_WIDTH_W-1:0]       pulse_width_o,
  output logic [mspw_pkg::OUT_CNT_W-1:0]         active_count_o,
  output logic [mspw_pkg::OUT_WIDTH_W-1:0]       strongest_width_o,
  output logic [mspw_pkg::OUT_IDX_W-1:0]         strongest_index_o,
  output logic                                   last_result_o
);

  localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned ACT_W = $clog2(SENSOR_COUNT + 1);
  localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(SENSOR_COUNT - 1);

  logic [mspw_pkg::WINDOW_W-1:0] window_q;
  logic [mspw_pkg::INC_W-1:0]    inc_q;
  logic [mspw_pkg::WINDOW_W-1:0] count_q, count_inc, limit;
  logic [WIDTH_BITS-1:0]         acc_q [SENSOR_COUNT];
  logic [WIDTH_BITS-1:0]         acc_d [SENSOR_COUNT];
  logic [IDX_W-1:0]              ptr_q;
  logic [ACT_W-1:0]              active_q;
  logic [WIDTH_BITS-1:0]         best_q;
  logic [IDX_W-1:0]              best_idx_q;
  logic [WIDTH_BITS-1:0]         cur;
  logic                          ptr_last;

  logic [mspw_pkg::OUT_IDX_W+IDX_W-1:0]             ptr_ext, best_idx_ext;
  logic [mspw_pkg::OUT_WIDTH_W+WIDTH_BITS-1:0]      cur_ext, best_ext;
  logic [mspw_pkg::OUT_CNT_W+ACT_W-1:0]             active_ext;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= mspw_pkg::WINDOW_RESET;
      inc_q    <= mspw_pkg::INC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mspw_pkg::CFG_WINDOW_SAMPLES:  window_q <= cfg_data_i;
        mspw_pkg::CFG_WIDTH_INCREMENT: inc_q    <= cfg_data_i[mspw_pkg::INC_W-1:0];
        default: ;
      endcase
    end
  end

  // window close detection
  assign count_inc = count_q + mspw_pkg::WINDOW_W'(1);
  assign limit     = (window_q == '0) ? mspw_pkg::WINDOW_W'(1) : window_q;
  assign ptr_last  = (ptr_q == PTR_LAST);
  assign status_o.close    = (count_inc >= limit) || (count_inc == '0);
  assign status_o.ptr_last = ptr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accum) begin
      count_q <= status_o.close ? '0 : count_inc;
    end
  end

  // per-sensor saturating accumulation
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    logic [WIDTH_BITS:0] sum;
    logic                low;
    assign sum = {1'b0, acc_q[g]} + (WIDTH_BITS + 1)'(inc_q);
    if (g < mspw_pkg::LEVEL_W) begin : g_pin
      assign low = ~sensor_levels_i[g];
    end else begin : g_nopin
      assign low = 1'b0;
    end
    always_comb begin
      acc_d[g] = acc_q[g];
      if (cmd_i.out_step && ptr_last) begin
        acc_d[g] = '0;
      end else if (cmd_i.accum && low) begin
        acc_d[g] = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[g] <= '0;
      end else begin
        acc_q[g] <= acc_d[g];
      end
    end
  end

  // scan and readout pointer
  assign cur = acc_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_step || cmd_i.out_step) begin
      ptr_q <= ptr_last ? '0 : ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      active_q   <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (cur != '0) begin
        active_q <= active_q + ACT_W'(1);
      end
      if (cur > best_q) begin
        best_q     <= cur;
        best_idx_q <= ptr_q;
      end
    end
  end

  // result fields, masked to port widths
  assign ptr_ext      = {{mspw_pkg::OUT_IDX_W{1'b0}}, ptr_q};
  assign best_idx_ext = {{mspw_pkg::OUT_IDX_W{1'b0}}, best_idx_q};
  assign cur_ext      = {{mspw_pkg::OUT_WIDTH_W{1'b0}}, cur};
  assign best_ext     = {{mspw_pkg::OUT_WIDTH_W{1'b0}}, best_q};
  assign active_ext   = {{mspw_pkg::OUT_CNT_W{1'b0}}, active_q};

  assign sensor_index_o    = ptr_ext[mspw_pkg::OUT_IDX_W-1:0];
  assign pulse_width_o     = cur_ext[mspw_pkg::OUT_WIDTH_W-1:0];
  assign active_count_o    = active_ext[mspw_pkg::OUT_CNT_W-1:0];
  assign strongest_width_o = best_ext[mspw_pkg::OUT_WIDTH_W-1:0];
  assign strongest_index_o = best_idx_ext[mspw_pkg::OUT_IDX_W-1:0];
  assign last_result_o     = ptr_last;

endmodule

[hdl/multi_sensor_pulse_width_window_unit.sv]
// top level of the multi-sensor pulse width window unit
// depends on mspw_pkg, mspw_ctrl and mspw_datapath
//
// usage: one beat on the s_axis side is one sample of the active-low sensor
// pins (bit i = sensor i, low = receiving). while a window is open the block
// takes one sample per cycle; each low pin adds width_increment to that
// sensor's saturating width.
// the sample that completes window_samples closes the window. the block then
// stops taking samples, scans the accumulators one sensor per cycle for the
// active count and the strongest sensor, and then presents SENSOR_COUNT
// result beats on the m_axis side in index order, tlast on the final one.
// the first result is valid once the scan is done; one result per cycle
// while m_axis_tready is high.
// if the receiver stalls, the current beat holds and no sample is taken
// until the readout is done; the accumulators clear with the last beat.
// reset clears widths and sample count and loads window_samples = 1000 and
// width_increment = 1. config writes (cfg_we_i, cfg_index_i, cfg_data_i)
// take effect at once; index 0 is window_samples, index 1 width_increment.
module multi_sensor_pulse_width_window_unit #(
  parameter int unsigned SENSOR_COUNT = 12,
  parameter int unsigned WIDTH_BITS   = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mspw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mspw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sensor_levels[11:0], zero pad
  input  logic [mspw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sensor_index[3:0], pulse_width[27:4], active_count[31:28],
  // strongest_width[55:32], strongest_index[59:56], zero pad
  output logic [mspw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  mspw_pkg::cmd_t    cmd;
  mspw_pkg::status_t status;

  logic [mspw_pkg::OUT_IDX_W-1:0]   sensor_index;
  logic [mspw_pkg::OUT_WIDTH_W-1:0] pulse_width;
  logic [mspw_pkg::OUT_CNT_W-1:0]   active_count;
  logic [mspw_pkg::OUT_WIDTH_W-1:0] strongest_width;
  logic [mspw_pkg::OUT_IDX_W-1:0]   strongest_index;

  mspw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mspw_datapath #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .WIDTH_BITS   (WIDTH_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sensor_levels_i   (s_axis_tdata[mspw_pkg::LEVEL_W-1:0]),
    .cmd_i             (cmd),
    .status_o          (status),
    .sensor_index_o    (sensor_index),
    .pulse_width_o     (pulse_width),
    .active_count_o    (active_count),
    .strongest_width_o (strongest_width),
    .strongest_index_o (strongest_index),
    .last_result_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, strongest_index, strongest_width, active_count,
                         pulse_width, sensor_index};

endmodule

[verif/tb_multi_sensor_pulse_width_window_unit.sv]
// self-checking testbench for multi_sensor_pulse_width_window_unit
// holds its own window predictor and scoreboard class, drives the stream and config ports
// depends on mspw_pkg and the unit's rtl
module tb_multi_sensor_pulse_width_window_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVEL_W     = mspw_pkg::LEVEL_W;
  localparam int unsigned WINDOW_W    = mspw_pkg::WINDOW_W;
  localparam int unsigned INC_W       = mspw_pkg::INC_W;
  localparam int unsigned OUT_IDX_W   = mspw_pkg::OUT_IDX_W;
  localparam int unsigned OUT_WIDTH_W = mspw_pkg::OUT_WIDTH_W;
  localparam int unsigned OUT_CNT_W   = mspw_pkg::OUT_CNT_W;
  localparam int unsigned CFG_IDX_W   = mspw_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W  = mspw_pkg::CFG_DATA_W;
  localparam int unsigned IN_TDATA_W  = mspw_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = mspw_pkg::OUT_TDATA_W;

  localparam int unsigned SENSORS        = 12;
  localparam int unsigned PW_LO          = OUT_IDX_W;
  localparam int unsigned CNT_LO         = PW_LO + OUT_WIDTH_W;
  localparam int unsigned SW_LO          = CNT_LO + OUT_CNT_W;
  localparam int unsigned SI_LO          = SW_LO + OUT_WIDTH_W;
  localparam int unsigned SCAN_SLACK     = 2 * SENSORS + 6;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RANDOM_SAMPLES = 380;
  localparam int unsigned LONG_WINDOW    = 65535;
  localparam int unsigned LONG_BURST     = 20;
  localparam int unsigned LONG_PEAK      = 5;
  localparam int unsigned PRINT_CAP      = 100;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]   sensor;
    logic [OUT_WIDTH_W-1:0] width;
    logic [OUT_CNT_W-1:0]   active;
    logic [OUT_WIDTH_W-1:0] peak_width;
    logic [OUT_IDX_W-1:0]   peak_sensor;
    logic                   last;
  } sensor_report_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_e;

  class pulse_window_tracker;
    logic [WINDOW_W-1:0]    window_len;
    logic [INC_W-1:0]       step_inc;
    logic [OUT_WIDTH_W-1:0] widths [SENSORS];
    logic [WINDOW_W-1:0]    taken;
    sensor_report_t         reports_due [$];
    int unsigned            errors;
    int unsigned            windows;
    int unsigned            beats;

    function new();
      window_len = mspw_pkg::WINDOW_RESET;
      step_inc   = mspw_pkg::INC_RESET;
      taken      = '0;
      foreach (widths[i]) widths[i] = '0;
      errors  = 0;
      windows = 0;
      beats   = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == mspw_pkg::CFG_WINDOW_SAMPLES) begin
        window_len = val[WINDOW_W-1:0];
      end else begin
        step_inc = val[INC_W-1:0];
      end
    endfunction

    function void take_sample(input logic [LEVEL_W-1:0] levels);
      logic [OUT_WIDTH_W:0]   sum;
      int unsigned            limit;
      int unsigned            active;
      logic [OUT_WIDTH_W-1:0] peak;
      logic [OUT_IDX_W-1:0]   peak_idx;
      sensor_report_t         r;
      for (int i = 0; i < SENSORS; i++) begin
        if (!levels[i]) begin
          sum = widths[i] + step_inc;
          widths[i] = sum[OUT_WIDTH_W] ? '1 : sum[OUT_WIDTH_W-1:0];
        end
      end
      taken++;
      limit = (window_len == 0) ? 1 : window_len;
      if (taken != 0 && taken < limit) return;
      active   = 0;
      peak     = '0;
      peak_idx = '0;
      for (int i = 0; i < SENSORS; i++) begin
        if (widths[i] != 0) active++;
        if (widths[i] > peak) begin
          peak     = widths[i];
          peak_idx = OUT_IDX_W'(i);
        end
      end
      for (int i = 0; i < SENSORS; i++) begin
        r.sensor      = OUT_IDX_W'(i);
        r.width       = widths[i];
        r.active      = OUT_CNT_W'(active);
        r.peak_width  = peak;
        r.peak_sensor = peak_idx;
        r.last        = (i == SENSORS - 1);
        reports_due.push_back(r);
        widths[i] = '0;
      end
      taken = '0;
      windows++;
    endfunction

    task report_mismatch(input string field, input longint unsigned got,
                         input longint unsigned want);
      if (errors < PRINT_CAP)
        $display("[%0t] mismatch beat %0d %s: got %0d want %0d", $time, beats, field, got, want);
      errors++;
    endtask

    task check_beat(input logic [OUT_TDATA_W-1:0] beat, input logic tlast);
      sensor_report_t want;
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected beat, sensor_index", beat[OUT_IDX_W-1:0], 0);
        beats++;
        return;
      end
      want = reports_due.pop_front();
      if (beat[OUT_IDX_W-1:0] != want.sensor)
        report_mismatch("sensor_index", beat[OUT_IDX_W-1:0], want.sensor);
      if (beat[PW_LO +: OUT_WIDTH_W] != want.width)
        report_mismatch("pulse_width", beat[PW_LO +: OUT_WIDTH_W], want.width);
      if (beat[CNT_LO +: OUT_CNT_W] != want.active)
        report_mismatch("active_count", beat[CNT_LO +: OUT_CNT_W], want.active);
      if (beat[SW_LO +: OUT_WIDTH_W] != want.peak_width)
        report_mismatch("strongest_width", beat[SW_LO +: OUT_WIDTH_W], want.peak_width);
      if (beat[SI_LO +: OUT_IDX_W] != want.peak_sensor)
        report_mismatch("strongest_index", beat[SI_LO +: OUT_IDX_W], want.peak_sensor);
      if (tlast !== want.last)
        report_mismatch("last_result", tlast, want.last);
      beats++;
    endtask
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  pulse_window_tracker tracker = new();

  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold  = 0;
  int unsigned cfg_writes  = 0;
  rx_mode_e    ready_mode  = RX_ALWAYS;

  multi_sensor_pulse_width_window_unit #(
    .SENSOR_COUNT (SENSORS),
    .WIDTH_BITS   (OUT_WIDTH_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode <= rx_mode_e'($urandom_range(0, 3));
      ready_hold <= $urandom_range(8, 48);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      RX_ALWAYS:      m_axis_tready <= 1'b1;
      RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
      RX_ONE_IN_FOUR: m_axis_tready <= (cycle_count[1:0] == 2'd0);
      default:        m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_beat(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [LEVEL_W-1:0] levels);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= levels;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_sample(levels);
    burst_left--;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] inc_word);
    wait_results_done();
    repeat (SCAN_SLACK) @(posedge clk_i);
    write_reg(mspw_pkg::CFG_WINDOW_SAMPLES, win);
    write_reg(mspw_pkg::CFG_WIDTH_INCREMENT, inc_word);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [LEVEL_W-1:0] pick_levels();
    logic [LEVEL_W-1:0] one_low;
    one_low = '1;
    one_low[4'($urandom_range(0, LEVEL_W - 1))] = 1'b0;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return one_low;
      3:       return LEVEL_W'($urandom) & LEVEL_W'($urandom);
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [LEVEL_W-1:0]    lv;
    logic [CFG_DATA_W-1:0] win;
    logic [INC_W-1:0]      inc;
    int unsigned           random_samples;
    int unsigned           phase_len;

    random_samples = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window length and increment, window stays open
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFE);
    // shorten below the count already taken, next beat closes
    configure(16'd3, 16'd1);
    send_sample(12'h7FF);
    // zero window and zero increment
    configure(16'd0, 16'd0);
    send_sample(12'h000);
    send_sample(12'hFFF);
    // one-sample windows, max increment with upper data bits set
    configure(16'd1, 16'hFFFF);
    send_sample(12'h000);
    send_sample(12'hF7F);
    send_sample(12'h7FF);
    configure(16'd2, 16'h00C8);
    send_sample(12'h0F0);
    send_sample(12'hF0F);
    send_sample(12'h3FF);
    send_sample(12'h3FE);

    // longest window at max increment, later shortened by the random phase
    configure(CFG_DATA_W'(LONG_WINDOW), 16'h00FF);
    for (int n = 0; n < LONG_BURST; n++) begin
      lv = LEVEL_W'($urandom);
      lv[LONG_PEAK] = 1'b0;
      send_sample(lv);
    end

    while (random_samples < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0:       win = 16'd0;
        1:       win = 16'd1;
        8:       win = CFG_DATA_W'($urandom_range(25, 90));
        default: win = CFG_DATA_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       inc = 8'd0;
        1:       inc = 8'hFF;
        default: inc = INC_W'($urandom_range(1, 254));
      endcase
      configure(win, {8'($urandom), inc});
      phase_len = $urandom_range(4, 48);
      repeat (phase_len) begin
        if ($urandom_range(0, 39) == 0) wait_results_done();
        send_sample(pick_levels());
        random_samples++;
      end
    end

    wait_results_done();
    repeat (SCAN_SLACK) @(posedge clk_i);
    $display("covered %0d closed windows, %0d result beats compared, %0d register writes",
             tracker.windows, tracker.beats, cfg_writes);
    $display("window lengths 0 to %0d, increments 0 to 255, shortened windows and ties included",
             LONG_WINDOW);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mspw_pkg.sv
hdl/mspw_ctrl.sv
hdl/mspw_datapath.sv
hdl/multi_sensor_pulse_width_window_unit.sv
verif/tb_multi_sensor_pulse_width_window_unit.sv
